FILE: sv/gddc_pkg.sv
`default_nettype none
package gddc_pkg;

	localparam int MAP_SIZE      = 32;
	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;
	localparam int TEX_SIZE      = 64;

	localparam int MAP_W     = $clog2(MAP_SIZE);
	localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
	localparam int ADDR_W    = 2 * MAP_W;
	localparam int MAX_STEPS = 2 * MAP_SIZE;
	localparam int STEP_W    = $clog2(MAX_STEPS + 1);
	localparam int CELL_W    = MAP_W + 3;
	localparam int TEX_W     = $clog2(TEX_SIZE);
	localparam int HALF_H    = SCREEN_HEIGHT / 2;

	localparam int NUM_W  = 33;
	localparam int DEN_W  = 40;
	localparam int DIST_W = 40;
	localparam int DCNT_W = 6;

	// camera offset column * 2^17 / SCREEN_WIDTH by a rounded-up reciprocal;
	// the extra 2*log2(width) bits keep the floor exact for every column
	localparam int     CAM_SH    = 2 * $clog2(SCREEN_WIDTH);
	localparam longint CAM_RECIP =
		((longint'(1) << (CAM_SH + 17)) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
	localparam int     RECIP_W   = $clog2(CAM_RECIP + 1);
	localparam int     CAM_P_W   = RECIP_W + 10;

	localparam logic [21:0] Q22_MAX = 22'h3FFFFF;

	localparam logic OPC_WRITE = 1'b1;

	localparam logic [2:0] REG_POS_X   = 3'd0;
	localparam logic [2:0] REG_POS_Y   = 3'd1;
	localparam logic [2:0] REG_DIR_X   = 3'd2;
	localparam logic [2:0] REG_DIR_Y   = 3'd3;
	localparam logic [2:0] REG_PLANE_X = 3'd4;
	localparam logic [2:0] REG_PLANE_Y = 3'd5;

	localparam logic [4:0] OP_NONE     = 5'd0;
	localparam logic [4:0] OP_CLEAR    = 5'd1;
	localparam logic [4:0] OP_WRITE    = 5'd2;
	localparam logic [4:0] OP_CAM      = 5'd4;
	localparam logic [4:0] OP_RAY      = 5'd5;
	localparam logic [4:0] OP_DIV_DDX  = 5'd6;
	localparam logic [4:0] OP_TAKE_DDX = 5'd7;
	localparam logic [4:0] OP_DIV_DDY  = 5'd8;
	localparam logic [4:0] OP_TAKE_DDY = 5'd9;
	localparam logic [4:0] OP_INIT     = 5'd10;
	localparam logic [4:0] OP_STEP     = 5'd11;
	localparam logic [4:0] OP_LH_SAT   = 5'd12;
	localparam logic [4:0] OP_DIV_LH   = 5'd13;
	localparam logic [4:0] OP_TAKE_LH  = 5'd14;
	localparam logic [4:0] OP_POST     = 5'd15;
	localparam logic [4:0] OP_STP_SAT  = 5'd16;
	localparam logic [4:0] OP_DIV_STP  = 5'd17;
	localparam logic [4:0] OP_TAKE_STP = 5'd18;
	localparam logic [4:0] OP_START    = 5'd19;
	localparam logic [4:0] OP_FIN_HIT  = 5'd20;
	localparam logic [4:0] OP_FIN_MISS = 5'd21;

	typedef struct packed {
		logic [4:0] op;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic zero_ray;
		logic rdx_zero;
		logic rdy_zero;
		logic hit;
		logic steps_done;
		logic perp_zero;
		logic lh_zero;
		logic clr_last;
	} sts_t;

endpackage
`default_nettype wire

FILE: sv/gddc_div.sv
`default_nettype none
module gddc_div (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire [gddc_pkg::NUM_W-1:0]   num,
	input  wire [gddc_pkg::DEN_W-1:0]   den,
	output logic                        busy,
	output logic [gddc_pkg::NUM_W-1:0]  quo
);
	import gddc_pkg::*;

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DEN_W:0]    trial;
	logic              fits;

	assign trial = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign busy  = cnt_q != '0;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DCNT_W'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// one quotient bit a cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end
endmodule
`default_nettype wire

FILE: sv/gddc_dp.sv
`default_nettype none
module gddc_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  gddc_pkg::cmd_t       cmd,
	output gddc_pkg::sts_t       sts,
	input  wire                  cfg_we,
	input  wire [2:0]            cfg_index,
	input  wire [20:0]           cfg_data,
	input  wire [9:0]            column,
	input  wire [4:0]            cell_x,
	input  wire [4:0]            cell_y,
	input  wire [2:0]            cell_value,
	output logic [2:0]           wall_code,
	output logic                 side,
	output logic [21:0]          perp_dist,
	output logic [15:0]          slice_height,
	output logic [8:0]           slice_top,
	output logic [8:0]           slice_bottom,
	output logic [5:0]           tex_column,
	output logic [21:0]          tex_step,
	output logic [21:0]          tex_start,
	output logic                 no_hit
);
	import gddc_pkg::*;

	logic [20:0]        pos_x_q, pos_y_q;
	logic signed [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

	logic [2:0]         map_q [0:MAP_DEPTH-1];
	logic [ADDR_W-1:0]  clr_cnt_q;
	logic [2:0]         rdata_q;
	logic               inmap_q;

	logic signed [17:0] cam_q;
	logic signed [20:0] rdx_q, rdy_q;
	logic [NUM_W-1:0]   ddx_q, ddy_q;
	logic [DIST_W-1:0]  sdx_q, sdy_q, perp_q;
	logic signed [CELL_W-1:0] mx_q, my_q;
	logic               side_q;
	logic [STEP_W-1:0]  nstep_q;
	logic [15:0]        lh_q;
	logic [8:0]         ds_q, de_q;
	logic [5:0]         tx_q;
	logic [21:0]        stp_q, tst_q;

	logic               div_start, div_busy;
	logic [NUM_W-1:0]   div_num, div_quo;
	logic [DEN_W-1:0]   div_den;

	logic [CAM_P_W-1:0] cam_p;
	logic [19:0]        abs_x, abs_y;
	logic signed [35:0] px, py;
	logic [16:0]        fx_m, fy_m;
	logic [49:0]        sx_p, sy_p;
	logic               take_x;
	logic signed [CELL_W-1:0] mx_n, my_n;
	logic               inmap_n;
	logic [ADDR_W-1:0]  raddr;
	logic [31:0]        tp;
	logic [31:0]        tp_a, tp_b;
	logic [15:0]        frac;
	logic [TEX_W-1:0]   tx_raw;
	logic               mirror;
	logic [14:0]        lh_half, term;
	logic [15:0]        de_sum;
	logic [36:0]        tst_p;
	logic               mem_we;
	logic [ADDR_W-1:0]  waddr;
	logic [2:0]         wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= 21'd1441792;
			pos_y_q   <= 21'd753664;
			dir_x_q   <= -18'sd65536;
			dir_y_q   <= '0;
			plane_x_q <= '0;
			plane_y_q <= 18'sd43254;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POS_X:   pos_x_q   <= cfg_data;
				REG_POS_Y:   pos_y_q   <= cfg_data;
				REG_DIR_X:   dir_x_q   <= cfg_data[17:0];
				REG_DIR_Y:   dir_y_q   <= cfg_data[17:0];
				REG_PLANE_X: plane_x_q <= cfg_data[17:0];
				REG_PLANE_Y: plane_y_q <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	assign abs_x = rdx_q[20] ? 20'(-rdx_q) : rdx_q[19:0];
	assign abs_y = rdy_q[20] ? 20'(-rdy_q) : rdy_q[19:0];

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (cmd.op)
			OP_DIV_DDX: begin
				div_start = 1'b1;
				div_num   = NUM_W'(1) << 32;
				div_den   = DEN_W'(abs_x);
			end
			OP_DIV_DDY: begin
				div_start = 1'b1;
				div_num   = NUM_W'(1) << 32;
				div_den   = DEN_W'(abs_y);
			end
			OP_DIV_LH: begin
				div_start = 1'b1;
				div_num   = NUM_W'(SCREEN_HEIGHT) << 16;
				div_den   = perp_q;
			end
			OP_DIV_STP: begin
				div_start = 1'b1;
				div_num   = NUM_W'(TEX_SIZE) << 16;
				div_den   = DEN_W'(lh_q);
			end
			default: ;
		endcase
	end

	gddc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.quo   (div_quo)
	);

	assign cam_p = CAM_P_W'(column) * CAM_P_W'(CAM_RECIP);

	assign px = plane_x_q * cam_q;
	assign py = plane_y_q * cam_q;

	assign fx_m = rdx_q[20] ? {1'b0, pos_x_q[15:0]} : 17'h10000 - {1'b0, pos_x_q[15:0]};
	assign fy_m = rdy_q[20] ? {1'b0, pos_y_q[15:0]} : 17'h10000 - {1'b0, pos_y_q[15:0]};
	assign sx_p = fx_m * ddx_q;
	assign sy_p = fy_m * ddy_q;

	// ties step along y
	assign take_x = (rdx_q != '0) && ((rdy_q == '0) || (sdx_q < sdy_q));
	always_comb begin
		mx_n = mx_q;
		my_n = my_q;
		if (take_x) begin
			mx_n = rdx_q[20] ? mx_q - 1'b1 : mx_q + 1'b1;
		end else begin
			my_n = rdy_q[20] ? my_q - 1'b1 : my_q + 1'b1;
		end
	end
	assign inmap_n = (mx_n >= 0) && (mx_n < CELL_W'(MAP_SIZE))
		&& (my_n >= 0) && (my_n < CELL_W'(MAP_SIZE));
	assign raddr = {mx_n[MAP_W-1:0], my_n[MAP_W-1:0]};

	// wall hit point: only the low 16 bits of the sum matter
	assign tp_a = perp_q[31:0];
	assign tp_b = side_q ? 32'(rdx_q) : 32'(rdy_q);
	assign tp   = tp_a * tp_b;
	assign frac = (side_q ? pos_x_q[15:0] : pos_y_q[15:0]) + tp[31:16];
	assign tx_raw = frac[15 -: TEX_W];
	assign mirror = (!side_q && !rdx_q[20] && (rdx_q != '0)) || (side_q && rdy_q[20]);

	assign lh_half = lh_q[15:1];
	assign de_sum  = 16'(HALF_H) + {1'b0, lh_half};
	assign term    = (lh_half > 15'(HALF_H)) ? lh_half - 15'(HALF_H) : '0;
	assign tst_p   = term * stp_q;

	always_comb begin
		mem_we = 1'b0;
		waddr  = clr_cnt_q;
		wdata  = '0;
		if (cmd.op == OP_CLEAR) begin
			mem_we = 1'b1;
		end else if (cmd.op == OP_WRITE) begin
			mem_we = (32'(cell_x) < MAP_SIZE) && (32'(cell_y) < MAP_SIZE);
			waddr  = {cell_x[MAP_W-1:0], cell_y[MAP_W-1:0]};
			wdata  = cell_value;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_q[waddr] <= wdata;
		end
		if (cmd.op == OP_STEP) begin
			rdata_q <= map_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.op == OP_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAM: cam_q <= 18'(cam_p >> CAM_SH) - 18'sd65536;
			OP_RAY: begin
				rdx_q <= 21'(dir_x_q) + 21'(px >>> 16);
				rdy_q <= 21'(dir_y_q) + 21'(py >>> 16);
			end
			OP_TAKE_DDX: ddx_q <= div_quo;
			OP_TAKE_DDY: ddy_q <= div_quo;
			OP_INIT: begin
				sdx_q   <= DIST_W'(sx_p >> 16);
				sdy_q   <= DIST_W'(sy_p >> 16);
				mx_q    <= CELL_W'(pos_x_q[20:16]);
				my_q    <= CELL_W'(pos_y_q[20:16]);
				nstep_q <= '0;
			end
			OP_STEP: begin
				mx_q    <= mx_n;
				my_q    <= my_n;
				inmap_q <= inmap_n;
				nstep_q <= nstep_q + 1'b1;
				side_q  <= !take_x;
				if (take_x) begin
					perp_q <= sdx_q;
					sdx_q  <= sdx_q + DIST_W'(ddx_q);
				end else begin
					perp_q <= sdy_q;
					sdy_q  <= sdy_q + DIST_W'(ddy_q);
				end
			end
			OP_LH_SAT:  lh_q <= 16'hFFFF;
			OP_TAKE_LH: lh_q <= (div_quo > NUM_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
			OP_POST: begin
				ds_q <= (lh_half >= 15'(HALF_H)) ? '0 : 9'(15'(HALF_H) - lh_half);
				de_q <= (de_sum >= 16'(SCREEN_HEIGHT)) ? 9'(SCREEN_HEIGHT - 1) : de_sum[8:0];
				tx_q <= 6'(mirror ? ~tx_raw : tx_raw);
			end
			OP_STP_SAT:  stp_q <= Q22_MAX;
			OP_TAKE_STP: stp_q <= (div_quo > NUM_W'(Q22_MAX)) ? Q22_MAX : div_quo[21:0];
			OP_START:    tst_q <= (tst_p > 37'(Q22_MAX)) ? Q22_MAX : tst_p[21:0];
			OP_FIN_HIT: begin
				wall_code    <= rdata_q;
				side         <= side_q;
				perp_dist    <= (perp_q > DIST_W'(Q22_MAX)) ? Q22_MAX : perp_q[21:0];
				slice_height <= lh_q;
				slice_top    <= ds_q;
				slice_bottom <= de_q;
				tex_column   <= tx_q;
				tex_step     <= stp_q;
				tex_start    <= tst_q;
				no_hit       <= 1'b0;
			end
			OP_FIN_MISS: begin
				wall_code    <= '0;
				side         <= 1'b0;
				perp_dist    <= '0;
				slice_height <= '0;
				slice_top    <= '0;
				slice_bottom <= '0;
				tex_column   <= '0;
				tex_step     <= '0;
				tex_start    <= '0;
				no_hit       <= 1'b1;
			end
			default: ;
		endcase
	end

	assign sts.div_busy   = div_busy;
	assign sts.rdx_zero   = rdx_q == '0;
	assign sts.rdy_zero   = rdy_q == '0;
	assign sts.zero_ray   = (rdx_q == '0) && (rdy_q == '0);
	assign sts.hit        = inmap_q && (rdata_q != '0);
	assign sts.steps_done = nstep_q == STEP_W'(MAX_STEPS);
	assign sts.perp_zero  = perp_q == '0;
	assign sts.lh_zero    = lh_q == '0;
	assign sts.clr_last   = clr_cnt_q == ADDR_W'(MAP_DEPTH - 1);
endmodule
`default_nettype wire

FILE: sv/gddc_ctrl.sv
`default_nettype none
module gddc_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire              opcode,
	input  wire [9:0]        column,
	output logic             out_valid,
	input  wire              out_ready,
	output gddc_pkg::cmd_t   cmd,
	input  gddc_pkg::sts_t   sts
);
	import gddc_pkg::*;

	localparam logic [4:0] S_CLR      = 5'd0;
	localparam logic [4:0] S_IDLE     = 5'd1;
	localparam logic [4:0] S_RAY      = 5'd3;
	localparam logic [4:0] S_DDX_GO   = 5'd4;
	localparam logic [4:0] S_DDX_W    = 5'd5;
	localparam logic [4:0] S_DDY_GO   = 5'd6;
	localparam logic [4:0] S_DDY_W    = 5'd7;
	localparam logic [4:0] S_INIT     = 5'd8;
	localparam logic [4:0] S_STEP     = 5'd9;
	localparam logic [4:0] S_WCHK     = 5'd10;
	localparam logic [4:0] S_LH_GO    = 5'd11;
	localparam logic [4:0] S_LH_W     = 5'd12;
	localparam logic [4:0] S_POST     = 5'd13;
	localparam logic [4:0] S_STP_GO   = 5'd14;
	localparam logic [4:0] S_STP_W    = 5'd15;
	localparam logic [4:0] S_START    = 5'd16;
	localparam logic [4:0] S_FIN      = 5'd17;
	localparam logic [4:0] S_FIN_MISS = 5'd18;

	logic [4:0] state_q, state_n;
	logic       ov_q;
	logic       out_free;
	logic       fin;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = ov_q;
	assign out_free  = !ov_q || out_ready;

	always_comb begin
		state_n = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_CLR: begin
				cmd.op = OP_CLEAR;
				if (sts.clr_last) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (opcode == OPC_WRITE) begin
						cmd.op = OP_WRITE;
					end else if (32'(column) < SCREEN_WIDTH) begin
						cmd.op  = OP_CAM;
						state_n = S_RAY;
					end
				end
			end
			S_RAY: begin
				cmd.op  = OP_RAY;
				state_n = S_DDX_GO;
			end
			S_DDX_GO: begin
				if (sts.zero_ray) begin
					state_n = S_FIN_MISS;
				end else if (sts.rdx_zero) begin
					state_n = S_DDY_GO;
				end else begin
					cmd.op  = OP_DIV_DDX;
					state_n = S_DDX_W;
				end
			end
			S_DDX_W: begin
				if (!sts.div_busy) begin
					cmd.op  = OP_TAKE_DDX;
					state_n = S_DDY_GO;
				end
			end
			S_DDY_GO: begin
				if (sts.rdy_zero) begin
					state_n = S_INIT;
				end else begin
					cmd.op  = OP_DIV_DDY;
					state_n = S_DDY_W;
				end
			end
			S_DDY_W: begin
				if (!sts.div_busy) begin
					cmd.op  = OP_TAKE_DDY;
					state_n = S_INIT;
				end
			end
			S_INIT: begin
				cmd.op  = OP_INIT;
				state_n = S_STEP;
			end
			S_STEP: begin
				cmd.op  = OP_STEP;
				state_n = S_WCHK;
			end
			S_WCHK: begin
				if (sts.hit) state_n = S_LH_GO;
				else if (sts.steps_done) state_n = S_FIN_MISS;
				else state_n = S_STEP;
			end
			S_LH_GO: begin
				if (sts.perp_zero) begin
					cmd.op  = OP_LH_SAT;
					state_n = S_POST;
				end else begin
					cmd.op  = OP_DIV_LH;
					state_n = S_LH_W;
				end
			end
			S_LH_W: begin
				if (!sts.div_busy) begin
					cmd.op  = OP_TAKE_LH;
					state_n = S_POST;
				end
			end
			S_POST: begin
				cmd.op  = OP_POST;
				state_n = S_STP_GO;
			end
			S_STP_GO: begin
				if (sts.lh_zero) begin
					cmd.op  = OP_STP_SAT;
					state_n = S_START;
				end else begin
					cmd.op  = OP_DIV_STP;
					state_n = S_STP_W;
				end
			end
			S_STP_W: begin
				if (!sts.div_busy) begin
					cmd.op  = OP_TAKE_STP;
					state_n = S_START;
				end
			end
			S_START: begin
				cmd.op  = OP_START;
				state_n = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.op  = OP_FIN_HIT;
					state_n = S_IDLE;
				end
			end
			S_FIN_MISS: begin
				if (out_free) begin
					cmd.op  = OP_FIN_MISS;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	assign fin = (cmd.op == OP_FIN_HIT) || (cmd.op == OP_FIN_MISS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (fin) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

FILE: sv/grid_dda_wall_column_caster_top.sv
`default_nettype none
// Wall column caster over a 32 x 32 grid map of 3-bit wall codes.
// Input channel (in_valid/in_ready): opcode 1 writes cell_value into the map
// at (cell_x, cell_y) and gives no result; opcode 0 casts a ray for screen
// column and gives one column descriptor on the output channel
// (out_valid/out_ready). Columns at or beyond the screen width are dropped.
// Configuration (cfg_we, cfg_index, cfg_data) sets position, direction and
// camera plane; write it only while no cast is in flight.
// A cast is dominated by up to four quotients through the shared
// one-bit-per-cycle divider and by one map read per DDA step.
// One item is worked on at a time; in_ready is high only between items.
// After reset the map is cleared by a sweep over all 1024 cells, one cell per
// cycle, with in_ready low; registers return to their reset view.
// A finished result waits in the output register; while out_ready is low a
// new item is still taken and runs until its own result is due, then holds.
module grid_dda_wall_column_caster_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         opcode,
	input  wire [9:0]   column,
	input  wire [4:0]   cell_x,
	input  wire [4:0]   cell_y,
	input  wire [2:0]   cell_value,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [2:0]  wall_code,
	output logic        side,
	output logic [21:0] perp_dist,
	output logic [15:0] slice_height,
	output logic [8:0]  slice_top,
	output logic [8:0]  slice_bottom,
	output logic [5:0]  tex_column,
	output logic [21:0] tex_step,
	output logic [21:0] tex_start,
	output logic        no_hit,
	input  wire         cfg_we,
	input  wire [2:0]   cfg_index,
	input  wire [20:0]  cfg_data
);
	import gddc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gddc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.column   (column),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	gddc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.column      (column),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cell_value  (cell_value),
		.wall_code   (wall_code),
		.side        (side),
		.perp_dist   (perp_dist),
		.slice_height(slice_height),
		.slice_top   (slice_top),
		.slice_bottom(slice_bottom),
		.tex_column  (tex_column),
		.tex_step    (tex_step),
		.tex_start   (tex_start),
		.no_hit      (no_hit)
	);

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_hit) |-> (perp_dist == '0 && slice_height == '0 && tex_step == '0))
		else $error("miss result carries nonzero fields");

	a_draw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !no_hit) |-> (slice_top <= slice_bottom))
		else $error("slice top below slice bottom");

	a_step_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !no_hit && slice_height == '0) |-> (tex_step == Q22_MAX))
		else $error("texture step not saturated for zero height");
endmodule
`default_nettype wire

FILE: bench/grid_dda_wall_column_caster_top_test.sv
`default_nettype none
module grid_dda_wall_column_caster_top_test;
	import gddc_pkg::*;

	localparam logic OPC_CAST = 1'b0;
	localparam int SETTLE_CYCLES = 400;

	typedef struct packed {
		logic [2:0]  wall_code;
		logic        side;
		logic [21:0] perp_dist;
		logic [15:0] slice_height;
		logic [8:0]  slice_top;
		logic [8:0]  slice_bottom;
		logic [5:0]  tex_column;
		logic [21:0] tex_step;
		logic [21:0] tex_start;
		logic        no_hit;
	} column_desc_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [9:0]  column;
	logic [4:0]  cell_x;
	logic [4:0]  cell_y;
	logic [2:0]  cell_value;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  wall_code;
	logic        side;
	logic [21:0] perp_dist;
	logic [15:0] slice_height;
	logic [8:0]  slice_top;
	logic [8:0]  slice_bottom;
	logic [5:0]  tex_column;
	logic [21:0] tex_step;
	logic [21:0] tex_start;
	logic        no_hit;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [20:0] cfg_data;

	grid_dda_wall_column_caster_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .column(column), .cell_x(cell_x), .cell_y(cell_y),
		.cell_value(cell_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.wall_code(wall_code), .side(side), .perp_dist(perp_dist),
		.slice_height(slice_height), .slice_top(slice_top),
		.slice_bottom(slice_bottom),
		.tex_column(tex_column), .tex_step(tex_step), .tex_start(tex_start),
		.no_hit(no_hit),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the block's map and view registers
	logic [2:0]        grid_map [MAP_DEPTH];
	logic [20:0]       view_pos_x, view_pos_y;
	logic signed [17:0] view_dir_x, view_dir_y, view_plane_x, view_plane_y;

	column_desc_t pending_columns[$];
	int errors;
	int casts_sent, writes_sent, dropped_casts, columns_checked, hits_seen;
	bit calm;
	int hold_left;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		#30000000;
		$display("** grid_dda_wall_column_caster_top: FAILED **");
		$finish;
	end

	function automatic longint cell_at(longint x, longint y);
		if (x < 0 || y < 0 || x >= MAP_SIZE || y >= MAP_SIZE)
			return 0;
		return grid_map[x * MAP_SIZE + y];
	endfunction

	function automatic longint sat22(longint v);
		return (v > longint'(Q22_MAX)) ? longint'(Q22_MAX) : v;
	endfunction

	function automatic column_desc_t cast_column(logic [9:0] col);
		column_desc_t r;
		longint cam, rx, ry, sdx, sdy, ddx, ddy, perp, mx, my, sx, sy;
		longint w, lh, ds, de, tx, stp, fx, fy;
		longint code;
		int n;
		bit hit, sd;
		r = '0;
		cam = (longint'(col) * 131072) / SCREEN_WIDTH - 65536;
		rx = longint'(view_dir_x) + ((longint'(view_plane_x) * cam) >>> 16);
		ry = longint'(view_dir_y) + ((longint'(view_plane_y) * cam) >>> 16);
		if (rx == 0 && ry == 0) begin
			r.no_hit = 1'b1;
			return r;
		end
		mx = longint'(view_pos_x[20:16]);
		my = longint'(view_pos_y[20:16]);
		fx = longint'(view_pos_x[15:0]);
		fy = longint'(view_pos_y[15:0]);
		sdx = 0; sdy = 0; ddx = 0; ddy = 0; sx = 1; sy = 1;
		if (rx != 0) begin
			ddx = (longint'(1) << 32) / (rx < 0 ? -rx : rx);
			if (rx < 0) begin
				sx = -1; sdx = (fx * ddx) >> 16;
			end else
				sdx = ((65536 - fx) * ddx) >> 16;
		end
		if (ry != 0) begin
			ddy = (longint'(1) << 32) / (ry < 0 ? -ry : ry);
			if (ry < 0) begin
				sy = -1; sdy = (fy * ddy) >> 16;
			end else
				sdy = ((65536 - fy) * ddy) >> 16;
		end
		hit = 0; sd = 0; perp = 0; code = 0;
		for (n = 0; n < MAX_STEPS && !hit; n++) begin
			// ties go along y
			if (rx != 0 && (ry == 0 || sdx < sdy)) begin
				perp = sdx; sdx += ddx; mx += sx; sd = 0;
			end else begin
				perp = sdy; sdy += ddy; my += sy; sd = 1;
			end
			code = cell_at(mx, my);
			hit = (code != 0);
		end
		if (!hit) begin
			r.no_hit = 1'b1;
			return r;
		end
		if (perp == 0)
			lh = 65535;
		else begin
			lh = (longint'(SCREEN_HEIGHT) << 16) / perp;
			if (lh > 65535)
				lh = 65535;
		end
		ds = HALF_H - lh / 2;
		if (ds < 0)
			ds = 0;
		de = HALF_H + lh / 2;
		if (de >= SCREEN_HEIGHT)
			de = SCREEN_HEIGHT - 1;
		if (!sd)
			w = longint'(view_pos_y) + ((perp * ry) >>> 16);
		else
			w = longint'(view_pos_x) + ((perp * rx) >>> 16);
		tx = ((w & 65535) * TEX_SIZE) >> 16;
		if ((!sd && rx > 0) || (sd && ry < 0))
			tx = TEX_SIZE - tx - 1;
		stp = (lh == 0) ? longint'(Q22_MAX) : sat22((longint'(TEX_SIZE) << 16) / lh);
		r.wall_code    = code[2:0];
		r.side         = sd;
		r.perp_dist    = sat22(perp);
		r.slice_height = lh[15:0];
		r.slice_top    = ds[8:0];
		r.slice_bottom = de[8:0];
		r.tex_column   = tx[5:0];
		r.tex_step     = stp[21:0];
		r.tex_start    = sat22((ds - HALF_H + lh / 2) * stp);
		return r;
	endfunction

	function automatic void compare_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		column_desc_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_columns.size() == 0) begin
				$display("%0t: column result with nothing expected, expected none, got %h",
					$time, {wall_code, side, perp_dist, no_hit});
				errors++;
			end else begin
				want = pending_columns.pop_front();
				compare_field("wall_code", want.wall_code, wall_code);
				compare_field("side", want.side, side);
				compare_field("perp_dist", want.perp_dist, perp_dist);
				compare_field("slice_height", want.slice_height, slice_height);
				compare_field("slice_top", want.slice_top, slice_top);
				compare_field("slice_bottom", want.slice_bottom, slice_bottom);
				compare_field("tex_column", want.tex_column, tex_column);
				compare_field("tex_step", want.tex_step, tex_step);
				compare_field("tex_start", want.tex_start, tex_start);
				compare_field("no_hit", want.no_hit, no_hit);
				columns_checked++;
				if (!want.no_hit)
					hits_seen++;
			end
		end
	end

	// result side: random stall bursts, long hold on request, none when calm
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (calm)
				out_ready <= 1'b1;
			else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 6);
			end else
				out_ready <= 1'b1;
		end
	end

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic send_item(logic op, logic [9:0] col, logic [4:0] cx, logic [4:0] cy,
		logic [2:0] val);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		column     <= col;
		cell_x     <= cx;
		cell_y     <= cy;
		cell_value <= val;
		do @(posedge clk); while (!in_ready);
		if (op == OPC_WRITE) begin
			grid_map[cx * MAP_SIZE + cy] = val;
			writes_sent++;
		end else if (col < SCREEN_WIDTH) begin
			pending_columns.push_back(cast_column(col));
			casts_sent++;
		end else
			dropped_casts++;
		@(negedge clk);
	endtask

	task automatic cast(logic [9:0] col);
		send_item(OPC_CAST, col, 5'($urandom), 5'($urandom), 3'($urandom));
	endtask

	task automatic put_cell(logic [4:0] cx, logic [4:0] cy, logic [2:0] val);
		send_item(OPC_WRITE, 10'($urandom), cx, cy, val);
	endtask

	// lower valid, let every column come back, then let the block settle
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_columns.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_view(logic [20:0] px, logic [20:0] py, logic signed [17:0] dx,
		logic signed [17:0] dy, logic signed [17:0] plx, logic signed [17:0] ply);
		logic [20:0] vals [6];
		// drop any item left offered by the last send
		in_valid <= 1'b0;
		vals = '{px, py, 21'(dx), 21'(dy), 21'(plx), 21'(ply)};
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		view_pos_x = px; view_pos_y = py;
		view_dir_x = dx; view_dir_y = dy;
		view_plane_x = plx; view_plane_y = ply;
		@(negedge clk);
	endtask

	task automatic build_walls(int density);
		for (int i = 0; i < MAP_SIZE; i++) begin
			put_cell(5'(i), 5'd0, 3'($urandom_range(1, 7)));
			put_cell(5'(i), 5'd31, 3'($urandom_range(1, 7)));
			put_cell(5'd0, 5'(i), 3'($urandom_range(1, 7)));
			put_cell(5'd31, 5'(i), 3'($urandom_range(1, 7)));
		end
		repeat (density)
			put_cell(5'($urandom_range(1, 30)), 5'($urandom_range(1, 30)),
				3'($urandom_range(0, 7)));
	endtask

	task automatic random_view;
		logic signed [17:0] d [4];
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(0, 3))
				0: d[i] = 18'($urandom);
				1: d[i] = 18'sd0;
				2: d[i] = 18'($signed($urandom_range(0, 8)) - 4);
				default: d[i] = 18'($signed($urandom_range(0, 131072)) - 65536);
			endcase
		end
		set_view({5'($urandom_range(1, 30)), 16'($urandom)},
			{5'($urandom_range(1, 30)), 16'($urandom)}, d[0], d[1], d[2], d[3]);
	endtask

	task automatic test_empty_map_and_edges;
		// no walls yet: every on-screen column runs out of steps
		cast(10'd0);
		cast(10'd639);
		cast(10'd640);
		cast(10'd1023);
		cast(10'd320);
		put_cell(5'd0, 5'd0, 3'd7);
		put_cell(5'd31, 5'd31, 3'd7);
		put_cell(5'd21, 5'd11, 3'd3);
		put_cell(5'd5, 5'd5, 3'd0);
		// reset view faces -x from 22.0 exactly: wall just ahead gives zero distance
		cast(10'd320);
		cast(10'd0);
		drain();
	endtask

	task automatic test_special_views;
		// zero ray
		set_view(21'h160000, 21'h0B8000, 18'sd0, 18'sd0, 18'sd0, 18'sd0);
		cast(10'd100);
		drain();
		// nearly flat ray along +x from mid-cell: distance so large the height is zero
		put_cell(5'd23, 5'd11, 3'd5);
		set_view(21'h168000, 21'h0B8000, 18'sd1, 18'sd0, 18'sd0, 18'sd0);
		cast(10'd320);
		cast(10'd639);
		drain();
		// extreme register values
		set_view(21'h1FFFFF, 21'h000000, -18'sd131072, 18'sd131071, 18'sd131071,
			-18'sd131072);
		cast(10'd0);
		cast(10'd639);
		drain();
		set_view(21'h000000, 21'h1FFFFF, 18'sd131071, -18'sd131072, -18'sd131072,
			18'sd131071);
		cast(10'd1);
		cast(10'd511);
		drain();
	endtask

	task automatic test_view_sweep;
		build_walls(60);
		for (int k = 0; k < 12; k++) begin
			random_view();
			repeat (25)
				cast(10'($urandom_range(0, 639)));
			drain();
		end
	endtask

	task automatic test_random_mix(int items);
		for (int i = 0; i < items; i++) begin
			if (i % 150 == 149) begin
				drain();
				random_view();
			end
			case ($urandom_range(0, 19))
				0, 1: put_cell(5'($urandom), 5'($urandom), 3'($urandom));
				2: put_cell(5'($urandom_range(1, 30)), 5'($urandom_range(1, 30)), 3'd0);
				3: cast(10'($urandom));
				default: cast(10'($urandom_range(0, 639)));
			endcase
		end
		drain();
	endtask

	task automatic test_output_hold;
		// results stall for a long stretch while columns keep coming
		hold_left = 900;
		repeat (8)
			cast(10'($urandom_range(0, 639)));
		drain();
	endtask

	task automatic test_calm_stream;
		calm = 1;
		repeat (120)
			cast(10'($urandom_range(0, 639)));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = 1'b0;
		column = '0;
		cell_x = '0;
		cell_y = '0;
		cell_value = '0;
		cfg_we = 1'b0;
		cfg_index = REG_POS_X;
		cfg_data = '0;
		calm = 0;
		hold_left = 0;
		errors = 0;
		casts_sent = 0; writes_sent = 0; dropped_casts = 0;
		columns_checked = 0; hits_seen = 0;
		foreach (grid_map[i])
			grid_map[i] = 3'd0;
		view_pos_x = 21'd1441792;
		view_pos_y = 21'd753664;
		view_dir_x = -18'sd65536;
		view_dir_y = 18'sd0;
		view_plane_x = 18'sd0;
		view_plane_y = 18'sd43254;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// wait out the map clearing sweep
		do @(posedge clk); while (!in_ready);
		@(negedge clk);

		test_empty_map_and_edges();
		test_special_views();
		test_view_sweep();
		test_output_hold();
		test_random_mix(515);
		test_calm_stream();

		$display("Covered %0d columns cast (%0d dropped off-screen), %0d map writes,",
			casts_sent, dropped_casts, writes_sent);
		$display("%0d descriptors checked, %0d of them wall hits.", columns_checked, hits_seen);
		if (errors == 0)
			$display("** grid_dda_wall_column_caster_top: PASSED **");
		else
			$display("** grid_dda_wall_column_caster_top: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
sv/gddc_pkg.sv
sv/gddc_div.sv
sv/gddc_dp.sv
sv/gddc_ctrl.sv
sv/grid_dda_wall_column_caster_top.sv
bench/grid_dda_wall_column_caster_top_test.sv
